// ----- hdl/hnf_pkg.sv -----
// ----------------------------------------------------------------------------
// High-pass and notch filter chain package
// Shared widths, register indexes, the multiply-accumulate control group and
// the rounding and saturation function of the filter chain.
// ----------------------------------------------------------------------------
package hnf_pkg;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 30;
  localparam int COEF_WIDTH     = 32;
  localparam int HP_COEF_WIDTH  = 31;
  localparam int OP_WIDTH       = SAMPLE_WIDTH + 2;
  localparam int PROD_WIDTH     = COEF_WIDTH + OP_WIDTH;
  localparam int ACC_WIDTH      = PROD_WIDTH + 3;
  localparam int REG_IDX_WIDTH  = 3;
  localparam int NUM_TAPS       = 5;
  localparam int TAP_WIDTH      = $clog2(NUM_TAPS);

  localparam logic [REG_IDX_WIDTH-1:0] REG_HP_ENABLE    = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_NOTCH_ENABLE = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_HP_COEF      = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_NOTCH_B0     = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_NOTCH_B1     = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_NOTCH_B2     = 3'd5;
  localparam logic [REG_IDX_WIDTH-1:0] REG_NOTCH_A1     = 3'd6;
  localparam logic [REG_IDX_WIDTH-1:0] REG_NOTCH_A2     = 3'd7;

  localparam logic signed [COEF_WIDTH-1:0] NOTCH_B0_RESET =
    COEF_WIDTH'(1) <<< COEF_FRAC_BITS;

  typedef struct packed {
    logic issue;
    logic first;
    logic sub;
  } mac_ctrl_t;

  // Scales an accumulated sum down by the coefficient fraction bits, rounding
  // the magnitude half away from zero, and saturates to the sample width.
  function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
    input logic signed [ACC_WIDTH-1:0] acc
  );
    localparam logic [ACC_WIDTH:0] Half = (ACC_WIDTH + 1)'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [ACC_WIDTH-COEF_FRAC_BITS:0] QLim =
      (ACC_WIDTH - COEF_FRAC_BITS + 1)'(1) << (SAMPLE_WIDTH - 1);
    logic [ACC_WIDTH-1:0]                mag;
    logic [ACC_WIDTH:0]                  rnd;
    logic [ACC_WIDTH-COEF_FRAC_BITS:0]   q;
    logic [SAMPLE_WIDTH-1:0]             ql;
    logic signed [SAMPLE_WIDTH-1:0]      res;
    mag = acc[ACC_WIDTH-1] ? ACC_WIDTH'(-acc) : ACC_WIDTH'(acc);
    rnd = {1'b0, mag} + Half;
    q   = rnd[ACC_WIDTH:COEF_FRAC_BITS];
    ql  = q[SAMPLE_WIDTH-1:0];
    if (acc[ACC_WIDTH-1]) begin
      if (q >= QLim) begin
        res = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
      end else begin
        res = $signed(-ql);
      end
    end else begin
      if (q >= QLim) begin
        res = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
      end else begin
        res = $signed(ql);
      end
    end
    return res;
  endfunction

endpackage

// ----- hdl/hnf_in_if.sv -----
// ----------------------------------------------------------------------------
// Input channel
// Valid and ready handshake carrying one raw sample item with its flags.
// ----------------------------------------------------------------------------
interface hnf_in_if;

  logic                                  valid;
  logic                                  ready;
  logic signed [hnf_pkg::SAMPLE_WIDTH-1:0] sample_in;
  logic                                  gap_in;
  logic                                  start_of_record;

  modport source (output valid, output sample_in, output gap_in,
                  output start_of_record, input ready);
  modport sink (input valid, input sample_in, input gap_in,
                input start_of_record, output ready);

endinterface

// ----- hdl/hnf_out_if.sv -----
// ----------------------------------------------------------------------------
// Output channel
// Valid and ready handshake carrying one filtered sample item.
// ----------------------------------------------------------------------------
interface hnf_out_if;

  logic                                  valid;
  logic                                  ready;
  logic signed [hnf_pkg::SAMPLE_WIDTH-1:0] sample_out;
  logic                                  gap_out;

  modport source (output valid, output sample_out, output gap_out, input ready);
  modport sink (input valid, input sample_out, input gap_out, output ready);

endinterface

// ----- hdl/hnf_mac.sv -----
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One signed multiplier with a registered product, followed by an adder that
// starts a new sum or adds or subtracts the product from the running sum.
// ----------------------------------------------------------------------------
module hnf_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  hnf_pkg::mac_ctrl_t                     ctrl_i,
  input  logic signed [hnf_pkg::COEF_WIDTH-1:0]  coef_i,
  input  logic signed [hnf_pkg::OP_WIDTH-1:0]    data_i,
  output logic signed [hnf_pkg::ACC_WIDTH-1:0]   acc_o
);

  logic signed [hnf_pkg::PROD_WIDTH-1:0] prod_q;
  logic                                  prod_vld_q;
  logic                                  first_q;
  logic                                  sub_q;
  logic signed [hnf_pkg::ACC_WIDTH-1:0]  acc_q;
  logic signed [hnf_pkg::ACC_WIDTH-1:0]  acc_d;
  logic signed [hnf_pkg::ACC_WIDTH-1:0]  prod_ext;
  logic signed [hnf_pkg::ACC_WIDTH-1:0]  base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      first_q    <= 1'b0;
      sub_q      <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.issue;
      first_q    <= ctrl_i.first;
      sub_q      <= ctrl_i.sub;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= coef_i * data_i;
    end
    acc_q <= acc_d;
  end

  always_comb begin
    prod_ext = hnf_pkg::ACC_WIDTH'(prod_q);
    base     = first_q ? '0 : acc_q;
    acc_d    = acc_q;
    if (prod_vld_q) begin
      acc_d = sub_q ? base - prod_ext : base + prod_ext;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- hdl/highpass_notch_filter_chain.sv -----
// ----------------------------------------------------------------------------
// High-pass and notch filter chain, top level
// High-pass multiply, wait and round run if enabled and primed, then notch tap
// products, wait and round if enabled; done registers the result when the output
// is free. A gap goes straight to done. No item is taken until idle, as up to six
// products go one at a time through the single shared multiplier. Reset clears all
// filter state, loads the register reset values and leaves the block ready.
// ----------------------------------------------------------------------------
module highpass_notch_filter_chain (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [hnf_pkg::REG_IDX_WIDTH-1:0]       cfg_idx_i,
  input  logic [hnf_pkg::COEF_WIDTH-1:0]          cfg_wdata_i,
  hnf_in_if.sink                                  item_i,
  hnf_out_if.source                               res_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_HP_MUL  = 4'd1;
  localparam logic [3:0] S_HP_WAIT = 4'd2;
  localparam logic [3:0] S_HP_RND  = 4'd3;
  localparam logic [3:0] S_NT_MUL  = 4'd4;
  localparam logic [3:0] S_NT_WAIT = 4'd5;
  localparam logic [3:0] S_NT_RND  = 4'd6;
  localparam logic [3:0] S_DONE    = 4'd7;

  localparam logic [hnf_pkg::TAP_WIDTH-1:0] TAP_B0   = 3'd0;
  localparam logic [hnf_pkg::TAP_WIDTH-1:0] TAP_B1   = 3'd1;
  localparam logic [hnf_pkg::TAP_WIDTH-1:0] TAP_B2   = 3'd2;
  localparam logic [hnf_pkg::TAP_WIDTH-1:0] TAP_A1   = 3'd3;
  localparam logic [hnf_pkg::TAP_WIDTH-1:0] TAP_A2   = 3'd4;

  logic                                       hp_en_q;
  logic                                       nt_en_q;
  logic [hnf_pkg::HP_COEF_WIDTH-1:0]          hp_coef_q;
  logic signed [hnf_pkg::COEF_WIDTH-1:0]      b0_q, b1_q, b2_q, a1_q, a2_q;

  logic [3:0]                                 state_q, state_d;
  logic [hnf_pkg::TAP_WIDTH-1:0]              tap_q, tap_d;
  logic                                       hp_primed_q, hp_primed_d;
  logic signed [hnf_pkg::SAMPLE_WIDTH-1:0]    hp_in_q, hp_in_d;
  logic signed [hnf_pkg::SAMPLE_WIDTH-1:0]    hp_out_q, hp_out_d;
  logic signed [hnf_pkg::SAMPLE_WIDTH-1:0]    xd0_q, xd0_d, xd1_q, xd1_d;
  logic signed [hnf_pkg::SAMPLE_WIDTH-1:0]    yd0_q, yd0_d, yd1_q, yd1_d;
  logic signed [hnf_pkg::SAMPLE_WIDTH-1:0]    cur_q, cur_d;
  logic                                       gap_q, gap_d;
  logic                                       out_vld_q, out_vld_d;
  logic signed [hnf_pkg::SAMPLE_WIDTH-1:0]    out_smp_q, out_smp_d;
  logic                                       out_gap_q, out_gap_d;

  hnf_pkg::mac_ctrl_t                         mac_ctrl;
  logic signed [hnf_pkg::COEF_WIDTH-1:0]      mac_coef;
  logic signed [hnf_pkg::OP_WIDTH-1:0]        mac_data;
  logic signed [hnf_pkg::ACC_WIDTH-1:0]       mac_acc;
  logic signed [hnf_pkg::SAMPLE_WIDTH-1:0]    rnd_y;
  logic                                       in_acc;
  logic                                       clr;

  hnf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (mac_coef),
    .data_i (mac_data),
    .acc_o  (mac_acc)
  );

  assign in_acc       = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == S_IDLE);
  assign rnd_y        = hnf_pkg::round_sat(mac_acc);
  assign res_o.valid      = out_vld_q;
  assign res_o.sample_out = out_smp_q;
  assign res_o.gap_out    = out_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_en_q   <= 1'b0;
      nt_en_q   <= 1'b0;
      hp_coef_q <= '0;
      b0_q      <= hnf_pkg::NOTCH_B0_RESET;
      b1_q      <= '0;
      b2_q      <= '0;
      a1_q      <= '0;
      a2_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hnf_pkg::REG_HP_ENABLE:    hp_en_q   <= cfg_wdata_i[0];
        hnf_pkg::REG_NOTCH_ENABLE: nt_en_q   <= cfg_wdata_i[0];
        hnf_pkg::REG_HP_COEF:      hp_coef_q <= cfg_wdata_i[hnf_pkg::HP_COEF_WIDTH-1:0];
        hnf_pkg::REG_NOTCH_B0:     b0_q      <= $signed(cfg_wdata_i);
        hnf_pkg::REG_NOTCH_B1:     b1_q      <= $signed(cfg_wdata_i);
        hnf_pkg::REG_NOTCH_B2:     b2_q      <= $signed(cfg_wdata_i);
        hnf_pkg::REG_NOTCH_A1:     a1_q      <= $signed(cfg_wdata_i);
        hnf_pkg::REG_NOTCH_A2:     a2_q      <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_q       <= '0;
      hp_primed_q <= 1'b0;
      hp_in_q     <= '0;
      hp_out_q    <= '0;
      xd0_q       <= '0;
      xd1_q       <= '0;
      yd0_q       <= '0;
      yd1_q       <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      hp_primed_q <= hp_primed_d;
      hp_in_q     <= hp_in_d;
      hp_out_q    <= hp_out_d;
      xd0_q       <= xd0_d;
      xd1_q       <= xd1_d;
      yd0_q       <= yd0_d;
      yd1_q       <= yd1_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    gap_q     <= gap_d;
    out_smp_q <= out_smp_d;
    out_gap_q <= out_gap_d;
  end

  always_comb begin
    mac_ctrl = '0;
    mac_coef = b0_q;
    mac_data = hnf_pkg::OP_WIDTH'(cur_q);
    unique case (state_q)
      S_HP_MUL: begin
        mac_ctrl = '{issue: 1'b1, first: 1'b1, sub: 1'b0};
        mac_coef = $signed({1'b0, hp_coef_q});
        mac_data = hnf_pkg::OP_WIDTH'(hp_out_q) + hnf_pkg::OP_WIDTH'(cur_q)
                   - hnf_pkg::OP_WIDTH'(hp_in_q);
      end
      S_NT_MUL: begin
        mac_ctrl.issue = 1'b1;
        mac_ctrl.first = (tap_q == TAP_B0);
        mac_ctrl.sub   = (tap_q == TAP_A1) || (tap_q == TAP_A2);
        unique case (tap_q)
          TAP_B0: begin
            mac_coef = b0_q;
            mac_data = hnf_pkg::OP_WIDTH'(cur_q);
          end
          TAP_B1: begin
            mac_coef = b1_q;
            mac_data = hnf_pkg::OP_WIDTH'(xd0_q);
          end
          TAP_B2: begin
            mac_coef = b2_q;
            mac_data = hnf_pkg::OP_WIDTH'(xd1_q);
          end
          TAP_A1: begin
            mac_coef = a1_q;
            mac_data = hnf_pkg::OP_WIDTH'(yd0_q);
          end
          default: begin
            mac_coef = a2_q;
            mac_data = hnf_pkg::OP_WIDTH'(yd1_q);
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    tap_d       = tap_q;
    hp_primed_d = hp_primed_q;
    hp_in_d     = hp_in_q;
    hp_out_d    = hp_out_q;
    xd0_d       = xd0_q;
    xd1_d       = xd1_q;
    yd0_d       = yd0_q;
    yd1_d       = yd1_q;
    cur_d       = cur_q;
    gap_d       = gap_q;
    out_smp_d   = out_smp_q;
    out_gap_d   = out_gap_q;
    out_vld_d   = out_vld_q && !res_o.ready;
    clr         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          clr   = item_i.start_of_record || item_i.gap_in;
          gap_d = item_i.gap_in;
          cur_d = item_i.sample_in;
          if (clr) begin
            hp_primed_d = 1'b0;
            hp_in_d     = '0;
            hp_out_d    = '0;
            xd0_d       = '0;
            xd1_d       = '0;
            yd0_d       = '0;
            yd1_d       = '0;
          end
          if (item_i.gap_in) begin
            cur_d   = '0;
            state_d = S_DONE;
          end else if (hp_en_q && hp_primed_q && !clr) begin
            state_d = S_HP_MUL;
          end else begin
            if (hp_en_q) begin
              // The first sample of a record primes the high-pass stage.
              hp_primed_d = 1'b1;
              hp_in_d     = item_i.sample_in;
              hp_out_d    = '0;
              cur_d       = '0;
            end
            state_d = nt_en_q ? S_NT_MUL : S_DONE;
          end
        end
      end
      S_HP_MUL:  state_d = S_HP_WAIT;
      S_HP_WAIT: state_d = S_HP_RND;
      S_HP_RND: begin
        hp_in_d  = cur_q;
        hp_out_d = rnd_y;
        cur_d    = rnd_y;
        state_d  = nt_en_q ? S_NT_MUL : S_DONE;
      end
      S_NT_MUL: begin
        if (tap_q == TAP_A2) begin
          tap_d   = '0;
          state_d = S_NT_WAIT;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      S_NT_WAIT: state_d = S_NT_RND;
      S_NT_RND: begin
        xd1_d   = xd0_q;
        xd0_d   = cur_q;
        yd1_d   = yd0_q;
        yd0_d   = rnd_y;
        cur_d   = rnd_y;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          out_vld_d = 1'b1;
          out_smp_d = cur_q;
          out_gap_d = gap_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !item_i.ready)
    else $error("A second item was taken while one was in work.");

  a_gap_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.gap_out |-> res_o.sample_out == '0)
    else $error("A gap item carries a nonzero sample.");

  a_gap_unprimes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && item_i.gap_in |=> !hp_primed_q && yd0_q == '0 && xd0_q == '0)
    else $error("A gap did not clear the filter state.");

  a_tap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_NT_MUL |-> tap_q == '0)
    else $error("The tap counter is not at its start outside the notch products.");

endmodule
